>>> rtl/ouvl_pkg.sv
package ouvl_pkg;

  localparam logic [2:0] ACT_APPEND   = 3'd0;
  localparam logic [2:0] ACT_PREPEND  = 3'd1;
  localparam logic [2:0] ACT_POP_HEAD = 3'd2;
  localparam logic [2:0] ACT_POP_TAIL = 3'd3;
  localparam logic [2:0] ACT_REMOVE   = 3'd4;
  localparam logic [2:0] ACT_SEARCH   = 3'd5;
  localparam logic [2:0] ACT_LIST     = 3'd6;
  localparam logic [2:0] ACT_NONE     = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam int CAPACITY = 16;
  localparam int VAL_W = 32;
  localparam int CNT_W = 5;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic                    found;
    logic signed [VAL_W-1:0] value_out;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } out_t;

endpackage

>>> rtl/ordered_unique_value_list_core.sv
// Flow from acceptance to first result beat: append, prepend, remove and search compare one
//   stored entry per cycle; a remove that closes a gap then shifts the later entries toward
//   the head. Pop reads one entry, list reads each entry in turn, and refused actions and an
//   insert into an empty list go straight to the result.
// Throughput: one item at a time, set by the single RAM read port and the comparator;
//   a new item is taken in the cycle after its predecessor's last result enters the output register.
// Reset (rst_n low, synchronous) empties the list; stored values are not cleared.
module ordered_unique_value_list_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ouvl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ouvl_pkg::out_t out_data
);
  import ouvl_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_POPA  = 3'd3;
  localparam logic [2:0] S_POPD  = 3'd4;
  localparam logic [2:0] S_LRD   = 3'd5;
  localparam logic [2:0] S_LDATA = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [SW-1:0]    head_r, head_nxt;
  logic [2:0]       act_r, act_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [SW-1:0]    rd_slot_r, rd_slot_nxt;
  logic [SW-1:0]    wr_slot_r, wr_slot_nxt;
  logic [SW-1:0]    cmp_slot_r, cmp_slot_nxt;
  logic [CW-1:0]    iss_r, iss_nxt;
  logic [CW-1:0]    cmp_pos_r, cmp_pos_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic             sv_r, sv_nxt;
  logic             more_r, more_nxt;
  out_t             res_r, res_nxt;
  out_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             we;
  logic [SW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [VAL_W-1:0] rd_data;

  logic [SW-1:0]    app_slot, tail_slot, pre_slot;
  logic [CW-1:0]    cnt_last, cnt_inc;
  logic             full, empty;
  logic             ins_go;
  logic [2:0]       ins_act;
  logic [VAL_W-1:0] ins_val;

  function automatic logic [SW-1:0] slot_wrap(input logic [SW:0] s);
    logic [SW:0] d;
    d = s - (SW+1)'(CAPACITY);
    return (s >= (SW+1)'(CAPACITY)) ? d[SW-1:0] : s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(CAPACITY - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic out_t mk_res(input logic [2:0] st, input logic fnd,
                                  input logic [VAL_W-1:0] v, input logic [CW-1:0] cnt,
                                  input logic lst);
    out_t r;
    r.status      = st;
    r.found       = fnd;
    r.value_out   = v;
    r.entry_count = CNT_W'(cnt);
    r.last        = lst;
    return r;
  endfunction

  ouvl_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_slot_r),
    .rdata(rd_data)
  );

  assign app_slot  = slot_wrap({1'b0, head_r} + (SW+1)'(count_r));
  assign tail_slot = slot_wrap({1'b0, head_r} + (SW+1)'(count_r) - 1'b1);
  assign pre_slot  = (head_r == '0) ? SW'(CAPACITY - 1) : head_r - 1'b1;
  assign cnt_last  = count_r - 1'b1;
  assign cnt_inc   = count_r + 1'b1;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    act_nxt       = act_r;
    val_nxt       = val_r;
    rd_slot_nxt   = rd_slot_r;
    wr_slot_nxt   = wr_slot_r;
    cmp_slot_nxt  = cmp_slot_r;
    iss_nxt       = iss_r;
    cmp_pos_nxt   = cmp_pos_r;
    cmp_v_nxt     = cmp_v_r;
    rem_nxt       = rem_r;
    sv_nxt        = sv_r;
    more_nxt      = more_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    waddr         = app_slot;
    wdata         = val_r;
    ins_go        = 1'b0;
    ins_act       = act_r;
    ins_val       = val_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_data.action;
          val_nxt     = in_data.value;
          rd_slot_nxt = head_r;
          iss_nxt     = '0;
          cmp_v_nxt   = 1'b0;
          more_nxt    = 1'b0;
          unique case (in_data.action) inside
            ACT_APPEND, ACT_PREPEND: begin
              if (full) begin
                res_nxt   = mk_res(ST_FULL, 1'b0, '0, count_r, 1'b1);
                state_nxt = S_EMIT;
              end else if (empty) begin
                ins_go  = 1'b1;
                ins_act = in_data.action;
                ins_val = in_data.value;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_POP_HEAD, ACT_POP_TAIL: begin
              if (empty) begin
                res_nxt   = mk_res(ST_EMPTY, 1'b0, '0, count_r, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                rd_slot_nxt = (in_data.action == ACT_POP_HEAD) ? head_r : tail_slot;
                state_nxt   = S_POPA;
              end
            end
            ACT_REMOVE, ACT_SEARCH, ACT_LIST: begin
              if (empty) begin
                res_nxt   = mk_res(ST_EMPTY, 1'b0, '0, count_r, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                state_nxt = (in_data.action == ACT_LIST) ? S_LRD : S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle, compare the one returned from the cycle before
        if (iss_r != count_r) begin
          cmp_v_nxt    = 1'b1;
          cmp_pos_nxt  = iss_r;
          cmp_slot_nxt = rd_slot_r;
          iss_nxt      = iss_r + 1'b1;
          rd_slot_nxt  = slot_inc(rd_slot_r);
        end else begin
          cmp_v_nxt = 1'b0;
        end
        if (cmp_v_r) begin
          if (rd_data == val_r) begin
            unique case (act_r) inside
              ACT_APPEND, ACT_PREPEND: begin
                res_nxt   = mk_res(ST_DUP, 1'b0, '0, count_r, 1'b1);
                state_nxt = S_EMIT;
              end
              ACT_SEARCH: begin
                res_nxt   = mk_res(ST_OK, 1'b1, '0, count_r, 1'b1);
                state_nxt = S_EMIT;
              end
              ACT_REMOVE: begin
                count_nxt = cnt_last;
                res_nxt   = mk_res(ST_OK, 1'b0, rd_data, cnt_last, 1'b1);
                if (cmp_pos_r == cnt_last) begin
                  state_nxt = S_EMIT;
                end else begin
                  // close the gap: move each later entry one slot toward the head
                  wr_slot_nxt = cmp_slot_r;
                  rd_slot_nxt = slot_inc(cmp_slot_r);
                  rem_nxt     = cnt_last - cmp_pos_r;
                  sv_nxt      = 1'b0;
                  state_nxt   = S_SHIFT;
                end
              end
              default: state_nxt = S_IDLE;
            endcase
          end else if (cmp_pos_r == cnt_last) begin
            unique case (act_r) inside
              ACT_APPEND, ACT_PREPEND: begin
                ins_go = 1'b1;
              end
              ACT_REMOVE, ACT_SEARCH: begin
                res_nxt   = mk_res(ST_NOTFOUND, 1'b0, '0, count_r, 1'b1);
                state_nxt = S_EMIT;
              end
              default: state_nxt = S_IDLE;
            endcase
          end
        end
      end

      S_SHIFT: begin
        if (rem_r != '0) begin
          sv_nxt      = 1'b1;
          rem_nxt     = rem_r - 1'b1;
          rd_slot_nxt = slot_inc(rd_slot_r);
        end else begin
          sv_nxt = 1'b0;
        end
        if (sv_r) begin
          we          = 1'b1;
          waddr       = wr_slot_r;
          wdata       = rd_data;
          wr_slot_nxt = slot_inc(wr_slot_r);
        end
        if (rem_r == '0 && !sv_r) begin
          state_nxt = S_EMIT;
        end
      end

      S_POPA: begin
        state_nxt = S_POPD;
      end

      S_POPD: begin
        count_nxt = cnt_last;
        if (act_r == ACT_POP_HEAD) begin
          head_nxt = slot_inc(head_r);
        end
        res_nxt   = mk_res(ST_OK, 1'b0, rd_data, cnt_last, 1'b1);
        state_nxt = S_EMIT;
      end

      S_LRD: begin
        state_nxt = S_LDATA;
      end

      S_LDATA: begin
        res_nxt     = mk_res(ST_OK, 1'b0, rd_data, count_r, iss_r == cnt_last);
        more_nxt    = (iss_r != cnt_last);
        iss_nxt     = iss_r + 1'b1;
        rd_slot_nxt = slot_inc(rd_slot_r);
        state_nxt   = S_EMIT;
      end

      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = more_r ? S_LRD : S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (ins_go) begin
      we    = 1'b1;
      wdata = ins_val;
      if (ins_act == ACT_APPEND) begin
        waddr = app_slot;
      end else begin
        waddr    = pre_slot;
        head_nxt = pre_slot;
      end
      count_nxt = cnt_inc;
      res_nxt   = mk_res(ST_OK, 1'b0, '0, cnt_inc, 1'b1);
      state_nxt = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      cmp_v_r     <= 1'b0;
      sv_r        <= 1'b0;
      rem_r       <= '0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      cmp_v_r     <= cmp_v_nxt;
      sv_r        <= sv_nxt;
      rem_r       <= rem_nxt;
      more_r      <= more_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    rd_slot_r  <= rd_slot_nxt;
    wr_slot_r  <= wr_slot_nxt;
    cmp_slot_r <= cmp_slot_nxt;
    iss_r      <= iss_nxt;
    cmp_pos_r  <= cmp_pos_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule

>>> rtl/ouvl_ram.sv
module ouvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ouvl_checker.sv
module ouvl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input ouvl_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input ouvl_pkg::out_t out_data
);
  import ouvl_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // every real action makes the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action != ACT_NONE) |=> !in_ready)
    else $error("input taken again right after an action");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.entry_count) <= CAPACITY))
    else $error("entry count above capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> (out_data.status == ST_OK) && out_data.last)
    else $error("found flag with a status other than ok");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> (out_data.entry_count == CNT_W'(CAPACITY)))
    else $error("full status reported below capacity");

endmodule

bind ordered_unique_value_list_core ouvl_checker u_ouvl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
